>>> design/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// widths, payload types and per-vertex result type of the triangle test
// ----------------------------------------------------------------------------
package pit_pkg;

    // coordinate width, signed q16.16
    localparam int COORD_W = 32;
    // p - vertex and edge differences
    localparam int DIFF_W  = COORD_W + 1;
    // one cross product component
    localparam int CROSS_W = 2 * DIFF_W + 1;
    // split of a cross component for the partial products of the dots
    localparam int LO_W    = (CROSS_W + 1) / 2;
    localparam int HI_W    = CROSS_W - LO_W;
    // partial product widths
    localparam int HH_W    = 2 * HI_W;
    localparam int HL_W    = HI_W + LO_W + 1;
    localparam int LL_W    = 2 * LO_W;
    // full dot term and sum of three terms
    localparam int PROD_W  = 2 * CROSS_W;
    localparam int SUM_W   = PROD_W + 2;

    // pipeline depth: difference stage, six vertex stages, output stage
    localparam int PIPE_N  = 8;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [COORD_W-1:0] vert_a_x;
        logic signed [COORD_W-1:0] vert_a_y;
        logic signed [COORD_W-1:0] vert_a_z;
        logic signed [COORD_W-1:0] vert_b_x;
        logic signed [COORD_W-1:0] vert_b_y;
        logic signed [COORD_W-1:0] vert_b_z;
        logic signed [COORD_W-1:0] vert_c_x;
        logic signed [COORD_W-1:0] vert_c_y;
        logic signed [COORD_W-1:0] vert_c_z;
    } t_in;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } t_out;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } t_dvec;

    typedef struct packed {
        logic ok;
        logic dg;
    } t_vres;

endpackage

>>> design/pit_vertex.sv
// ----------------------------------------------------------------------------
// pit_vertex
// weight test for one vertex: n = edge x opp, m = rel x opp,
// num = n.m, den = n.n, ok when den is nonzero and 0 <= num <= den, degenerate when den is zero
// six register stages, advanced by i_en
// ----------------------------------------------------------------------------
module pit_vertex (
    input  logic          i_clk,
    input  logic          i_en,
    input  pit_pkg::t_dvec i_edge,
    input  pit_pkg::t_dvec i_opp,
    input  pit_pkg::t_dvec i_rel,
    output pit_pkg::t_vres o_res
);
    import pit_pkg::*;

    logic signed [2*DIFF_W-1:0] r_np [6];
    logic signed [2*DIFF_W-1:0] r_mp [6];
    logic signed [CROSS_W-1:0]  r_n  [3];
    logic signed [CROSS_W-1:0]  r_m  [3];
    logic signed [HH_W-1:0]     r_nm_hh [3];
    logic signed [HL_W-1:0]     r_nm_hl [3];
    logic signed [HL_W-1:0]     r_nm_lh [3];
    logic        [LL_W-1:0]     r_nm_ll [3];
    logic signed [HH_W-1:0]     r_nn_hh [3];
    logic signed [HL_W-1:0]     r_nn_hl [3];
    logic signed [HL_W-1:0]     r_nn_lh [3];
    logic        [LL_W-1:0]     r_nn_ll [3];
    logic signed [PROD_W-1:0]   r_pnm [3];
    logic signed [PROD_W-1:0]   r_pnn [3];
    logic signed [SUM_W-1:0]    r_num;
    logic signed [SUM_W-1:0]    r_den;
    t_vres                      r_res;

    // stage 2: the twelve cross product terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_np[0] <= i_edge.y * i_opp.z;
            r_np[1] <= i_edge.z * i_opp.y;
            r_np[2] <= i_edge.z * i_opp.x;
            r_np[3] <= i_edge.x * i_opp.z;
            r_np[4] <= i_edge.x * i_opp.y;
            r_np[5] <= i_edge.y * i_opp.x;
            r_mp[0] <= i_rel.y * i_opp.z;
            r_mp[1] <= i_rel.z * i_opp.y;
            r_mp[2] <= i_rel.z * i_opp.x;
            r_mp[3] <= i_rel.x * i_opp.z;
            r_mp[4] <= i_rel.x * i_opp.y;
            r_mp[5] <= i_rel.y * i_opp.x;
        end
    end

    // stage 3: cross product components
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= CROSS_W'(r_np[2*k]) - CROSS_W'(r_np[2*k+1]);
                r_m[k] <= CROSS_W'(r_mp[2*k]) - CROSS_W'(r_mp[2*k+1]);
            end
        end
    end

    // stage 4: partial products, high half signed, low half unsigned
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_nm_hh[k] <= $signed(r_n[k][CROSS_W-1:LO_W])
                            * $signed(r_m[k][CROSS_W-1:LO_W]);
                r_nm_hl[k] <= $signed(r_n[k][CROSS_W-1:LO_W])
                            * $signed({1'b0, r_m[k][LO_W-1:0]});
                r_nm_lh[k] <= $signed(r_m[k][CROSS_W-1:LO_W])
                            * $signed({1'b0, r_n[k][LO_W-1:0]});
                r_nm_ll[k] <= r_n[k][LO_W-1:0] * r_m[k][LO_W-1:0];
                r_nn_hh[k] <= $signed(r_n[k][CROSS_W-1:LO_W])
                            * $signed(r_n[k][CROSS_W-1:LO_W]);
                r_nn_hl[k] <= $signed(r_n[k][CROSS_W-1:LO_W])
                            * $signed({1'b0, r_n[k][LO_W-1:0]});
                r_nn_lh[k] <= $signed(r_n[k][CROSS_W-1:LO_W])
                            * $signed({1'b0, r_n[k][LO_W-1:0]});
                r_nn_ll[k] <= r_n[k][LO_W-1:0] * r_n[k][LO_W-1:0];
            end
        end
    end

    // stage 5: recombine the partials into full dot terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pnm[k] <= (PROD_W'(r_nm_hh[k]) <<< (2*LO_W))
                          + ((PROD_W'(r_nm_hl[k]) + PROD_W'(r_nm_lh[k])) <<< LO_W)
                          + $signed(PROD_W'(r_nm_ll[k]));
                r_pnn[k] <= (PROD_W'(r_nn_hh[k]) <<< (2*LO_W))
                          + ((PROD_W'(r_nn_hl[k]) + PROD_W'(r_nn_lh[k])) <<< LO_W)
                          + $signed(PROD_W'(r_nn_ll[k]));
            end
        end
    end

    // stage 6: dot sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= SUM_W'(r_pnm[0]) + SUM_W'(r_pnm[1]) + SUM_W'(r_pnm[2]);
            r_den <= SUM_W'(r_pnn[0]) + SUM_W'(r_pnn[1]) + SUM_W'(r_pnn[2]);
        end
    end

    // stage 7: range check of the weight
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.dg <= (r_den == '0);
            r_res.ok <= (r_den != '0) && !r_num[SUM_W-1] && (r_num <= r_den);
        end
    end

    assign o_res = r_res;

endmodule

>>> design/point_in_triangle_test_top.sv
// ----------------------------------------------------------------------------
// point_in_triangle_test_top
// barycentric point-in-triangle test, exact fixed point, fully pipelined
// ----------------------------------------------------------------------------
// channel  valid    ready    payload
// input    i_valid  o_ready  i_data (point and three vertices)
// output   o_valid  i_ready  o_data (inside_res, degenerate)
//
// one request enters per cycle while o_ready is high; eight register stages
// (difference stage, six vertex stages, output register) lie between a
// request and its result, which is offered from the output register.
// the whole pipeline advances together; when the output register is full
// and not taken, every stage holds and o_ready drops.
// synchronous active-low reset clears the valid bits only.
// ----------------------------------------------------------------------------
module point_in_triangle_test_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pit_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output pit_pkg::t_out o_data
);
    import pit_pkg::*;

    logic               en;
    logic [PIPE_N-1:0]  r_vld;
    t_dvec              r_ab, r_bc, r_ca, r_cb, r_ba, r_ac, r_ai, r_bi, r_ci;
    t_vres              res_a, res_b, res_c;
    t_out               r_out;

    // pipeline advances unless the output holds an untaken result
    assign en      = !r_vld[PIPE_N-1] || i_ready;
    assign o_ready = en;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_N-2:0], i_valid};
        end
    end

    // stage 1: edge and point differences
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ab.x <= DIFF_W'(i_data.vert_b_x) - DIFF_W'(i_data.vert_a_x);
            r_ab.y <= DIFF_W'(i_data.vert_b_y) - DIFF_W'(i_data.vert_a_y);
            r_ab.z <= DIFF_W'(i_data.vert_b_z) - DIFF_W'(i_data.vert_a_z);
            r_bc.x <= DIFF_W'(i_data.vert_c_x) - DIFF_W'(i_data.vert_b_x);
            r_bc.y <= DIFF_W'(i_data.vert_c_y) - DIFF_W'(i_data.vert_b_y);
            r_bc.z <= DIFF_W'(i_data.vert_c_z) - DIFF_W'(i_data.vert_b_z);
            r_ca.x <= DIFF_W'(i_data.vert_a_x) - DIFF_W'(i_data.vert_c_x);
            r_ca.y <= DIFF_W'(i_data.vert_a_y) - DIFF_W'(i_data.vert_c_y);
            r_ca.z <= DIFF_W'(i_data.vert_a_z) - DIFF_W'(i_data.vert_c_z);
            r_cb.x <= DIFF_W'(i_data.vert_b_x) - DIFF_W'(i_data.vert_c_x);
            r_cb.y <= DIFF_W'(i_data.vert_b_y) - DIFF_W'(i_data.vert_c_y);
            r_cb.z <= DIFF_W'(i_data.vert_b_z) - DIFF_W'(i_data.vert_c_z);
            r_ba.x <= DIFF_W'(i_data.vert_a_x) - DIFF_W'(i_data.vert_b_x);
            r_ba.y <= DIFF_W'(i_data.vert_a_y) - DIFF_W'(i_data.vert_b_y);
            r_ba.z <= DIFF_W'(i_data.vert_a_z) - DIFF_W'(i_data.vert_b_z);
            r_ac.x <= DIFF_W'(i_data.vert_c_x) - DIFF_W'(i_data.vert_a_x);
            r_ac.y <= DIFF_W'(i_data.vert_c_y) - DIFF_W'(i_data.vert_a_y);
            r_ac.z <= DIFF_W'(i_data.vert_c_z) - DIFF_W'(i_data.vert_a_z);
            r_ai.x <= DIFF_W'(i_data.point_x) - DIFF_W'(i_data.vert_a_x);
            r_ai.y <= DIFF_W'(i_data.point_y) - DIFF_W'(i_data.vert_a_y);
            r_ai.z <= DIFF_W'(i_data.point_z) - DIFF_W'(i_data.vert_a_z);
            r_bi.x <= DIFF_W'(i_data.point_x) - DIFF_W'(i_data.vert_b_x);
            r_bi.y <= DIFF_W'(i_data.point_y) - DIFF_W'(i_data.vert_b_y);
            r_bi.z <= DIFF_W'(i_data.point_z) - DIFF_W'(i_data.vert_b_z);
            r_ci.x <= DIFF_W'(i_data.point_x) - DIFF_W'(i_data.vert_c_x);
            r_ci.y <= DIFF_W'(i_data.point_y) - DIFF_W'(i_data.vert_c_y);
            r_ci.z <= DIFF_W'(i_data.point_z) - DIFF_W'(i_data.vert_c_z);
        end
    end

    // stages 2 to 7: one weight test per vertex
    pit_vertex u_vert_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_edge (r_ab),
        .i_opp  (r_cb),
        .i_rel  (r_ai),
        .o_res  (res_a)
    );

    pit_vertex u_vert_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_edge (r_bc),
        .i_opp  (r_ac),
        .i_rel  (r_bi),
        .o_res  (res_b)
    );

    pit_vertex u_vert_c (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_edge (r_ca),
        .i_opp  (r_ba),
        .i_rel  (r_ci),
        .o_res  (res_c)
    );

    // stage 8: output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.degenerate <= res_a.dg || res_b.dg || res_c.dg;
            r_out.inside_res <= res_a.ok && res_b.ok && res_c.ok;
        end
    end

    assign o_valid = r_vld[PIPE_N-1];
    assign o_data  = r_out;

endmodule
